@@ rtl/pn3d_pkg.sv @@
package pn3d_pkg;

	typedef logic [7:0] perm_byte_t;

	localparam int unsigned NumCopies = 7;

	// h mod 12 for a byte: q = floor(h / 12) by reciprocal 171 / 2048
	function automatic logic [3:0] mod12(input perm_byte_t h);
		logic [15:0] prod;
		logic [4:0] q;
		logic [7:0] rem;
		prod = 16'(h) * 16'd171;
		q = prod[15:11];
		rem = h - 8'(q * 8'd12);
		return rem[3:0];
	endfunction

endpackage

@@ rtl/perlin_noise_3d_top.sv @@
// An accepted evaluate word passes stages 1 to 9 and the output register to reach rsp.
// Throughput: one word per cycle; the 10-stage pipeline only holds when the
// output register is full and rsp_stall is high. Load words give no result.
// Reset clears the pipeline valid bits; the permutation table copies are not
// cleared and must be loaded before they are used.
module perlin_noise_3d_top import pn3d_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic                 op,
	input  logic [7:0]           perm_index,
	input  logic [7:0]           perm_value,
	input  logic [23:0]          coord_x,
	input  logic [23:0]          coord_y,
	input  logic [23:0]          coord_z,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic signed [17:0]   noise
);

	localparam int FB  = FRAC_BITS;
	localparam int W   = FB + 3;          // corner and mix values
	localparam int FW  = FB + 6;          // fade polynomial term
	localparam int FPW = 2 * FB + 7;      // fade products
	localparam int TW  = FB + 2;          // fade weight, signed
	localparam int PW  = W + TW + 1;      // mix products
	localparam int RW  = W + 17;          // rescaled result
	localparam int SHR = (FB > 16) ? FB - 16 : 0;
	localparam int SHL = (FB < 16) ? 16 - FB : 0;
	localparam logic signed [W-1:0]  ONE_W   = W'(1) <<< FB;
	localparam logic signed [FW-1:0] FIFTEEN = FW'(15) <<< FB;
	localparam logic signed [FW-1:0] TEN     = FW'(10) <<< FB;
	localparam logic signed [RW-1:0] SAT_HI  = RW'(131071);
	localparam logic signed [RW-1:0] SAT_LO  = -RW'(131072);

	logic adv;

	// permutation table copies: copy 0 for z, 1-2 for y, 3-6 for x
	perm_byte_t perm_q [NumCopies][256];
	perm_byte_t rd_q   [NumCopies][2];
	perm_byte_t ra     [NumCopies][2];

	logic [31:0] cx_ext, cy_ext, cz_ext;
	perm_byte_t  xi, yi, zi;
	logic [FB-1:0] fr [3];

	// stage 1
	logic        vld_s1, ev_s1, ld_s1;
	perm_byte_t  idx_s1, val_s1, x_s1, y_s1;
	logic [FB-1:0] f_s1 [3];
	// stage 2
	logic        vld_s2, ev_s2, ld_s2;
	perm_byte_t  idx_s2, val_s2, x_s2;
	logic [FB-1:0] f_s2 [3];
	logic signed [FPW-1:0] fa_s2 [3];
	logic [2*FB-1:0] tt_s2 [3];
	// stage 3
	logic        vld_s3, ev_s3;
	logic [FB-1:0] f_s3 [3];
	logic signed [FW-1:0] p_s3 [3];
	logic [2*FB-1:0] t3_s3 [3];
	// stage 4
	logic        vld_s4, ev_s4;
	logic signed [FPW-1:0] fp_s4 [3];
	logic signed [W-1:0] n_s4 [8];
	// stage 5
	logic        vld_s5, ev_s5;
	logic signed [PW-1:0] xp_s5 [4];
	logic signed [W-1:0]  xa_s5 [4];
	logic signed [TW-1:0] v_s5, w_s5;
	// stage 6
	logic        vld_s6, ev_s6;
	logic signed [W-1:0]  x_s6 [4];
	logic signed [TW-1:0] v_s6, w_s6;
	// stage 7
	logic        vld_s7, ev_s7;
	logic signed [PW-1:0] yp_s7 [2];
	logic signed [W-1:0]  ya_s7 [2];
	logic signed [TW-1:0] w_s7;
	// stage 8
	logic        vld_s8, ev_s8;
	logic signed [W-1:0]  y_s8 [2];
	logic signed [TW-1:0] w_s8;
	// stage 9
	logic        vld_s9, ev_s9;
	logic signed [PW-1:0] zp_s9;
	logic signed [W-1:0]  za_s9;

	logic        out_vld_q;
	logic signed [17:0] noise_q;

	function automatic logic signed [W-1:0] grad_dot(input logic [3:0] gi,
			input logic signed [W-1:0] dx, input logic signed [W-1:0] dy,
			input logic signed [W-1:0] dz);
		logic signed [W-1:0] d;
		unique case (gi)
			4'd0:    d =  dx + dy;
			4'd1:    d = -dx + dy;
			4'd2:    d =  dx - dy;
			4'd3:    d = -dx - dy;
			4'd4:    d =  dx + dz;
			4'd5:    d = -dx + dz;
			4'd6:    d =  dx - dz;
			4'd7:    d = -dx - dz;
			4'd8:    d =  dy + dz;
			4'd9:    d = -dy + dz;
			4'd10:   d =  dy - dz;
			4'd11:   d = -dy - dz;
			default: d = '0;
		endcase
		return d;
	endfunction

	assign adv       = !(out_vld_q && rsp_stall);
	assign req_stall = !adv;
	assign rsp_valid = out_vld_q;
	assign noise     = noise_q;

	assign cx_ext = 32'(coord_x);
	assign cy_ext = 32'(coord_y);
	assign cz_ext = 32'(coord_z);
	assign xi = 8'(cx_ext >> FB);
	assign yi = 8'(cy_ext >> FB);
	assign zi = 8'(cz_ext >> FB);
	assign fr[0] = coord_x[FB-1:0];
	assign fr[1] = coord_y[FB-1:0];
	assign fr[2] = coord_z[FB-1:0];

	// table read addresses for each hash level
	always_comb begin
		ra[0][0] = zi;
		ra[0][1] = zi + 8'd1;
		for (int k = 0; k < 2; k++) begin
			ra[1+k][0] = y_s1 + rd_q[0][k];
			ra[1+k][1] = y_s1 + 8'd1 + rd_q[0][k];
		end
		for (int q = 0; q < 4; q++) begin
			ra[3+q][0] = x_s2 + rd_q[1+q/2][q%2];
			ra[3+q][1] = x_s2 + 8'd1 + rd_q[1+q/2][q%2];
		end
	end

	// each copy is written at the stage that reads it, so accesses keep word order
	always_ff @(posedge clk) begin
		if (adv) begin
			if (req_valid && !op)
				perm_q[0][perm_index] <= perm_value;
			if (ld_s1) begin
				perm_q[1][idx_s1] <= val_s1;
				perm_q[2][idx_s1] <= val_s1;
			end
			if (ld_s2) begin
				for (int c = 3; c < NumCopies; c++)
					perm_q[c][idx_s2] <= val_s2;
			end
			for (int c = 0; c < NumCopies; c++) begin
				rd_q[c][0] <= perm_q[c][ra[c][0]];
				rd_q[c][1] <= perm_q[c][ra[c][1]];
			end
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0; vld_s4 <= 1'b0;
			vld_s5 <= 1'b0; vld_s6 <= 1'b0; vld_s7 <= 1'b0; vld_s8 <= 1'b0;
			vld_s9 <= 1'b0; out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
			out_vld_q <= vld_s9 && ev_s9;
		end
	end

	assign ld_s1 = vld_s1 && !ev_s1;
	assign ld_s2 = vld_s2 && !ev_s2;

	// datapath
	always_ff @(posedge clk) begin
		if (adv) begin
			logic signed [FW-1:0]  tw;
			logic signed [FW-1:0]  e6;
			logic signed [FPW-1:0] fa_sh;
			logic [3:0]            gi;
			logic signed [W-1:0]   d [3][2];
			logic signed [RW-1:0]  rext, rs;
			logic signed [W-1:0]   r;

			// stage 1
			ev_s1  <= op;
			idx_s1 <= perm_index;
			val_s1 <= perm_value;
			x_s1   <= xi;
			y_s1   <= yi;
			for (int a = 0; a < 3; a++)
				f_s1[a] <= fr[a];

			// stage 2: fade products t*(6t-15) and t*t
			ev_s2  <= ev_s1;
			idx_s2 <= idx_s1;
			val_s2 <= val_s1;
			x_s2   <= x_s1;
			for (int a = 0; a < 3; a++) begin
				tw = signed'(FW'(f_s1[a]));
				e6 = (tw <<< 2) + (tw <<< 1) - FIFTEEN;
				fa_s2[a] <= FPW'(tw) * FPW'(e6);
				tt_s2[a] <= (2*FB)'(f_s1[a]) * (2*FB)'(f_s1[a]);
				f_s2[a]  <= f_s1[a];
			end

			// stage 3
			ev_s3 <= ev_s2;
			for (int a = 0; a < 3; a++) begin
				fa_sh = fa_s2[a] >>> FB;
				p_s3[a]  <= FW'(fa_sh) + TEN;
				t3_s3[a] <= (2*FB)'(tt_s2[a] >> FB) * (2*FB)'(f_s2[a]);
				f_s3[a]  <= f_s2[a];
			end

			// stage 4: fade product and corner dot products
			ev_s4 <= ev_s3;
			for (int a = 0; a < 3; a++) begin
				fp_s4[a] <= signed'(FPW'(t3_s3[a] >> FB)) * FPW'(p_s3[a]);
				d[a][0] = signed'(W'(f_s3[a]));
				d[a][1] = signed'(W'(f_s3[a])) - ONE_W;
			end
			for (int c = 0; c < 8; c++) begin
				gi = mod12(rd_q[3 + ((c >> 1) & 1) + 2*((c >> 2) & 1)][c & 1]);
				n_s4[c] <= grad_dot(gi, d[0][c & 1], d[1][(c >> 1) & 1],
					d[2][(c >> 2) & 1]);
			end

			// stage 5: x mix products
			ev_s5 <= ev_s4;
			for (int q = 0; q < 4; q++) begin
				xa_s5[q] <= n_s4[2*q];
				xp_s5[q] <= PW'(TW'(fp_s4[0] >>> FB)) *
					PW'(n_s4[2*q+1] - n_s4[2*q]);
			end
			v_s5 <= TW'(fp_s4[1] >>> FB);
			w_s5 <= TW'(fp_s4[2] >>> FB);

			// stage 6
			ev_s6 <= ev_s5;
			for (int q = 0; q < 4; q++)
				x_s6[q] <= xa_s5[q] + W'(xp_s5[q] >>> FB);
			v_s6 <= v_s5;
			w_s6 <= w_s5;

			// stage 7: y mix products, x index is j + 2k
			ev_s7 <= ev_s6;
			for (int k = 0; k < 2; k++) begin
				ya_s7[k] <= x_s6[2*k];
				yp_s7[k] <= PW'(v_s6) * PW'(x_s6[2*k+1] - x_s6[2*k]);
			end
			w_s7 <= w_s6;

			// stage 8
			ev_s8 <= ev_s7;
			for (int k = 0; k < 2; k++)
				y_s8[k] <= ya_s7[k] + W'(yp_s7[k] >>> FB);
			w_s8 <= w_s7;

			// stage 9: z mix product
			ev_s9 <= ev_s8;
			za_s9 <= y_s8[0];
			zp_s9 <= PW'(w_s8) * PW'(y_s8[1] - y_s8[0]);

			// output: finish the mix, rescale to 16 fraction bits, saturate
			r    = za_s9 + W'(zp_s9 >>> FB);
			rext = RW'(r);
			rs   = (rext >>> SHR) <<< SHL;
			if (rs > SAT_HI)
				noise_q <= 18'(SAT_HI);
			else if (rs < SAT_LO)
				noise_q <= 18'(SAT_LO);
			else
				noise_q <= 18'(rs);
		end
	end

	a_stall_only_downstream: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("input stalled without a held result");

	a_eval_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s9 && ev_s9 && !req_stall |=> rsp_valid)
		else $error("evaluate word lost at output");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s9 && !ev_s9 && !req_stall |=> !rsp_valid)
		else $error("load word produced a result");

endmodule
